>>> hw/rtl/tbma_pkg.sv
package tbma_pkg;

   localparam int PRICE_W   = 32;
   localparam int MINUTE_W  = 11;
   localparam int WINDOW_W  = 7;
   localparam int COUNT_W   = 7;
   localparam int SUM_W     = PRICE_W + WINDOW_W;
   localparam int DIV_CNT_W = $clog2(SUM_W);

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic                op;
      logic [PRICE_W-1:0]  price;
      logic [MINUTE_W-1:0] minute_of_day;
      logic [WINDOW_W-1:0] window;
   } req_type;

   typedef struct packed {
      logic [PRICE_W-1:0] average;
      logic               average_valid;
      logic [PRICE_W-1:0] bar_open;
      logic [PRICE_W-1:0] bar_high;
      logic [PRICE_W-1:0] bar_low;
      logic [PRICE_W-1:0] bar_close;
      logic [COUNT_W-1:0] bar_count;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic done;
   } div_ctl_type;

endpackage

>>> hw/rtl/tbma_ring_mem.sv
module tbma_ring_mem
   import tbma_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [PRICE_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output logic [PRICE_W-1:0] rd_data
);

   logic [PRICE_W-1:0] mem_ff [DEPTH];
   logic [PRICE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/tbma_divider.sv
module tbma_divider
   import tbma_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SUM_W-1:0]    dividend,
   input  logic [WINDOW_W-1:0] divisor,
   output logic                done,
   output logic [PRICE_W-1:0]  quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [WINDOW_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [WINDOW_W-1:0]  dsr_ff, dsr_in;
   logic [WINDOW_W:0]    shifted;
   logic [WINDOW_W:0]    diff;
   logic                 ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[SUM_W-1]};
      ge      = shifted >= {1'b0, dsr_ff};
      diff    = shifted - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[WINDOW_W-1:0] : shifted[WINDOW_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[PRICE_W-1:0];

endmodule

>>> hw/rtl/tick_bar_moving_average.sv
// Builds one-minute OHLC bars from price ticks and answers simple moving-average
// queries over the closes of the newest WINDOW_DEPTH bars, held in a ring memory.
// One word is taken at a time. A tick, or a query whose window is 0 or exceeds the
// bar count, is answered in the cycle after it is taken. A valid query over k
// closes makes k reads through the single read port of the ring memory, then runs
// a 39-step restoring divider that yields one quotient bit per cycle. Every result
// word carries the newest bar and the bar count after the word is applied.
module tick_bar_moving_average
   import tbma_pkg::*;
#(
   parameter int WINDOW_DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   localparam int AW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int CMP_W = (CNT_W > WINDOW_W) ? CNT_W : WINDOW_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SUM  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_word_ff, rsp_word_in;
   logic [AW-1:0]       slot_ff, slot_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [MINUTE_W-1:0] minute_ff, minute_in;
   logic [PRICE_W-1:0]  open_ff, open_in;
   logic [PRICE_W-1:0]  high_ff, high_in;
   logic [PRICE_W-1:0]  low_ff, low_in;
   logic [PRICE_W-1:0]  close_ff, close_in;
   logic [WINDOW_W-1:0] win_ff, win_in;
   logic [WINDOW_W-1:0] issued_ff, issued_in;
   logic [AW-1:0]       raddr_ff, raddr_in;
   logic                pend_ff, pend_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [PRICE_W-1:0]  avg_ff, avg_in;

   logic               accept;
   logic               out_free;
   logic               same_bar;
   logic               query_ok;
   logic [CMP_W-1:0]   count_ext;
   logic [CMP_W-1:0]   count_in_ext;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic               rd_en;
   logic [PRICE_W-1:0] rd_data;
   div_ctl_type        div_ctl;
   logic               div_done;
   logic [PRICE_W-1:0] quotient;

   function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] s);
      return (s == AW'(WINDOW_DEPTH - 1)) ? '0 : s + 1'b1;
   endfunction

   function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] s);
      return (s == '0) ? AW'(WINDOW_DEPTH - 1) : s - 1'b1;
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == ST_IDLE && out_free);
   assign accept    = req_valid && !req_stall;
   assign count_ext = CMP_W'(count_ff);
   assign same_bar  = (count_ff != '0) && (req_word.minute_of_day == minute_ff);
   assign query_ok  = (req_word.window != '0) && (CMP_W'(req_word.window) <= count_ext);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      slot_in      = slot_ff;
      count_in     = count_ff;
      minute_in    = minute_ff;
      open_in      = open_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      close_in     = close_ff;
      win_in       = win_ff;
      issued_in    = issued_ff;
      raddr_in     = raddr_ff;
      pend_in      = 1'b0;
      sum_in       = sum_ff;
      avg_in       = avg_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;
      rd_en        = 1'b0;
      div_ctl      = '0;
      div_ctl.done = div_done;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_word.op == OP_TICK) begin
                  close_in = req_word.price;
                  if (same_bar) begin
                     if (req_word.price > high_ff) begin
                        high_in = req_word.price;
                     end
                     if (req_word.price < low_ff) begin
                        low_in = req_word.price;
                     end
                  end else begin
                     if (count_ff != '0) begin
                        slot_in = slot_next(slot_ff);
                     end
                     if (count_ext < CMP_W'(WINDOW_DEPTH)) begin
                        count_in = count_ff + 1'b1;
                     end
                     open_in   = req_word.price;
                     high_in   = req_word.price;
                     low_in    = req_word.price;
                     minute_in = req_word.minute_of_day;
                  end
                  wr_en   = 1'b1;
                  wr_addr = slot_in;
               end
               if (req_word.op == OP_QUERY && query_ok) begin
                  state_in  = ST_SUM;
                  win_in    = req_word.window;
                  issued_in = '0;
                  raddr_in  = slot_ff;
                  sum_in    = '0;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_SUM: begin
            if (pend_ff) begin
               sum_in = sum_ff + SUM_W'(rd_data);
            end
            if (issued_ff != win_ff) begin
               rd_en     = 1'b1;
               pend_in   = 1'b1;
               issued_in = issued_ff + 1'b1;
               raddr_in  = slot_prev(raddr_ff);
            end else if (!pend_ff) begin
               div_ctl.start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_ctl.done) begin
               avg_in   = quotient;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      count_in_ext = CMP_W'(count_in);
      if (state_ff == ST_IDLE || (state_ff == ST_DONE && out_free)) begin
         if (rsp_valid_in && !(rsp_valid_ff && rsp_stall)) begin
            rsp_word_in.average       = (state_ff == ST_DONE) ? avg_ff : '0;
            rsp_word_in.average_valid = (state_ff == ST_DONE);
            rsp_word_in.bar_open      = open_in;
            rsp_word_in.bar_high      = high_in;
            rsp_word_in.bar_low       = low_in;
            rsp_word_in.bar_close     = (count_in != '0) ? close_in : '0;
            rsp_word_in.bar_count     = count_in_ext[COUNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         slot_ff      <= '0;
         count_ff     <= '0;
         minute_ff    <= '0;
         open_ff      <= '0;
         high_ff      <= '0;
         low_ff       <= '1;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         slot_ff      <= slot_in;
         count_ff     <= count_in;
         minute_ff    <= minute_in;
         open_ff      <= open_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      close_ff    <= close_in;
      win_ff      <= win_in;
      issued_ff   <= issued_in;
      raddr_ff    <= raddr_in;
      sum_ff      <= sum_in;
      avg_ff      <= avg_in;
   end

   tbma_ring_mem #(
      .DEPTH (WINDOW_DEPTH),
      .AW    (AW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_word.price),
      .rd_en   (rd_en),
      .rd_addr (raddr_ff),
      .rd_data (rd_data)
   );

   tbma_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_ctl.start),
      .dividend (sum_ff),
      .divisor  (win_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
